### design/pic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants for the incremental pi controller
// Field widths, configuration register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned SpeedW   = 8;
  localparam int unsigned GainW    = 8;
  localparam int unsigned ThreshW  = 16;
  localparam int unsigned ClampW   = 8;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned ErrW     = SpeedW + 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  // wide enough for drive + (kp+ki)*e - kp*e_prev with sign
  localparam int unsigned CandW    = 21;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_INTEG_GAIN      = 3'd1,
    CFG_UPPER_THRESHOLD = 3'd2,
    CFG_LOWER_THRESHOLD = 3'd3,
    CFG_UPPER_VALUE     = 3'd4,
    CFG_LOWER_VALUE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]   prop_gain;
    logic [GainW-1:0]   integ_gain;
    logic [ThreshW-1:0] upper_threshold;
    logic [ThreshW-1:0] lower_threshold;
    logic [ClampW-1:0]  upper_value;
    logic [ClampW-1:0]  lower_value;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:       '0,
    integ_gain:      '0,
    upper_threshold: '1,
    lower_threshold: '0,
    upper_value:     '1,
    lower_value:     '0
  };

endpackage

### design/pic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_in_if: input channel
// Valid/ready channel carrying setpoint and measured speed.
// ----------------------------------------------------------------------------
interface pic_in_if;
  import pic_pkg::*;

  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] setpoint;
  logic [SpeedW-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

### design/pic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_out_if: result channel
// Valid/ready channel carrying the clamped drive value.
// ----------------------------------------------------------------------------
interface pic_out_if;
  import pic_pkg::*;

  logic              valid;
  logic              ready;
  logic [DriveW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

### design/pic_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_cfg: configuration registers
// Write-only register file for gains, clamp thresholds and clamp values.
// ----------------------------------------------------------------------------
module pic_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pic_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pic_pkg::CfgDataW-1:0]  cfg_data_i,
  output pic_pkg::cfg_t                 cfg_o
);
  import pic_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:       cfg_d.prop_gain       = cfg_data_i[GainW-1:0];
        CFG_INTEG_GAIN:      cfg_d.integ_gain      = cfg_data_i[GainW-1:0];
        CFG_UPPER_THRESHOLD: cfg_d.upper_threshold = cfg_data_i[ThreshW-1:0];
        CFG_LOWER_THRESHOLD: cfg_d.lower_threshold = cfg_data_i[ThreshW-1:0];
        CFG_UPPER_VALUE:     cfg_d.upper_value     = cfg_data_i[ClampW-1:0];
        CFG_LOWER_VALUE:     cfg_d.lower_value     = cfg_data_i[ClampW-1:0];
        default:             cfg_d = cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pic_law.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_law: incremental pi control law with two-sided clamp
// Forms the error, the candidate drive and the clamped drive in one pass.
// ----------------------------------------------------------------------------
module pic_law (
  input  pic_pkg::cfg_t                     cfg_i,
  input  logic [pic_pkg::SpeedW-1:0]        setpoint_i,
  input  logic [pic_pkg::SpeedW-1:0]        measured_i,
  input  logic signed [pic_pkg::ErrW-1:0]   last_error_i,
  input  logic [pic_pkg::DriveW-1:0]        last_drive_i,
  output logic signed [pic_pkg::ErrW-1:0]   error_o,
  output logic [pic_pkg::DriveW-1:0]        drive_o
);
  import pic_pkg::*;

  localparam int unsigned SumW   = GainW + 1;
  localparam int unsigned ProdAW = SumW + 1 + ErrW;
  localparam int unsigned ProdBW = GainW + 1 + ErrW;

  logic signed [ErrW-1:0]   err;
  logic signed [SumW:0]     gain_sum;
  logic signed [GainW:0]    kp_s;
  logic signed [ProdAW-1:0] prod_a;
  logic signed [ProdBW-1:0] prod_b;
  logic signed [CandW-1:0]  cand;
  logic signed [CandW-1:0]  upper_ext;
  logic signed [CandW-1:0]  lower_ext;
  logic [DriveW-1:0]        drive;

  always_comb begin
    err = signed'({1'b0, setpoint_i}) - signed'({1'b0, measured_i});
    gain_sum = signed'({2'b00, cfg_i.prop_gain} + {2'b00, cfg_i.integ_gain});
    kp_s     = signed'({1'b0, cfg_i.prop_gain});
    prod_a   = gain_sum * err;
    prod_b   = kp_s * last_error_i;
    cand = signed'({{(CandW-DriveW){1'b0}}, last_drive_i})
         + {{(CandW-ProdAW){prod_a[ProdAW-1]}}, prod_a}
         - {{(CandW-ProdBW){prod_b[ProdBW-1]}}, prod_b};

    upper_ext = signed'({{(CandW-ThreshW){1'b0}}, cfg_i.upper_threshold});
    lower_ext = signed'({{(CandW-ThreshW){1'b0}}, cfg_i.lower_threshold});

    // low clamp is checked first and wins when both hold
    priority if (cand <= lower_ext) begin
      drive = {{(DriveW-ClampW){1'b0}}, cfg_i.lower_value};
    end else if (cand >= upper_ext) begin
      drive = {{(DriveW-ClampW){1'b0}}, cfg_i.upper_value};
    end else begin
      drive = cand[DriveW-1:0];
    end
  end

  assign error_o = err;
  assign drive_o = drive;

endmodule

### design/incremental_pi_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_clamped: incremental pi speed controller with clamp
// Input register, single-pass control law and result register.
// ----------------------------------------------------------------------------
// path: an item passes the input reg and then the result reg on its way to the result
// transfer; result valid rises when the result stage advances, which a stalled output holds off
// throughput: 1 item per cycle while the output is not stalled; the error/drive state loop
// closes through the control law between the input register and the result register
// reset: config to defaults, previous error and drive to zero, both stages empty
module incremental_pi_clamped (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pic_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pic_pkg::CfgDataW-1:0]  cfg_data_i,
  pic_in_if.sink                        in_if,
  pic_out_if.source                     out_if
);
  import pic_pkg::*;

  cfg_t cfg;

  logic                   in_valid_d, in_valid_q;
  logic [SpeedW-1:0]      setpoint_q, measured_q;
  logic                   out_valid_d, out_valid_q;
  logic [DriveW-1:0]      drive_q;
  logic signed [ErrW-1:0] last_error_q;
  logic [DriveW-1:0]      last_drive_q;
  logic signed [ErrW-1:0] error;
  logic [DriveW-1:0]      drive;
  logic                   advance;
  logic                   in_xfer;

  pic_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pic_law u_law (
    .cfg_i        (cfg),
    .setpoint_i   (setpoint_q),
    .measured_i   (measured_q),
    .last_error_i (last_error_q),
    .last_drive_i (last_drive_q),
    .error_o      (error),
    .drive_o      (drive)
  );

  // result stage can take a new value when empty or being drained
  assign advance      = !out_valid_q || out_if.ready;
  assign in_if.ready  = !in_valid_q || advance;
  assign in_xfer      = in_if.valid && in_if.ready;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
    if (in_if.ready) begin
      in_valid_d = in_if.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_error_q <= '0;
      last_drive_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && in_valid_q) begin
        last_error_q <= error;
        last_drive_q <= drive;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      setpoint_q <= in_if.setpoint;
      measured_q <= in_if.measured;
    end
    if (advance && in_valid_q) begin
      drive_q <= drive;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.drive = drive_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clamped incremental pi controller
// Setpoint/measured pairs go in under random idling on both channels; each
// drive that comes out is checked against a local copy of the control law,
// its saved error/drive state and the clamp settings.
// ----------------------------------------------------------------------------
import pic_pkg::*;

class drive_tracker;
  cfg_t                   regs;
  logic signed [ErrW-1:0] last_err;
  logic [DriveW-1:0]      last_drive;
  logic [DriveW-1:0]      pending_drive[$];
  int unsigned            n_checked;
  int unsigned            n_failed;

  function new();
    regs       = CfgReset;
    last_err   = '0;
    last_drive = '0;
    n_checked  = 0;
    n_failed   = 0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_PROP_GAIN:       regs.prop_gain       = data[GainW-1:0];
      CFG_INTEG_GAIN:      regs.integ_gain      = data[GainW-1:0];
      CFG_UPPER_THRESHOLD: regs.upper_threshold = data[ThreshW-1:0];
      CFG_LOWER_THRESHOLD: regs.lower_threshold = data[ThreshW-1:0];
      CFG_UPPER_VALUE:     regs.upper_value     = data[ClampW-1:0];
      CFG_LOWER_VALUE:     regs.lower_value     = data[ClampW-1:0];
      default: ;
    endcase
  endfunction

  function logic [DriveW-1:0] next_drive(logic [SpeedW-1:0] sp, logic [SpeedW-1:0] ms);
    int                err;
    int                cand;
    logic [DriveW-1:0] drv;
    err  = int'(sp) - int'(ms);
    cand = int'(last_drive) + (int'(regs.prop_gain) + int'(regs.integ_gain)) * err
           - int'(regs.prop_gain) * int'(last_err);
    if (cand >= int'(regs.upper_threshold)) begin
      drv = DriveW'(regs.upper_value);
    end else begin
      drv = cand[DriveW-1:0];
    end
    // low clamp is tested last so it wins when both hold
    if (cand <= int'(regs.lower_threshold)) begin
      drv = DriveW'(regs.lower_value);
    end
    last_err   = err[ErrW-1:0];
    last_drive = drv;
    return drv;
  endfunction

  function void take_speed(logic [SpeedW-1:0] sp, logic [SpeedW-1:0] ms);
    pending_drive.push_back(next_drive(sp, ms));
  endfunction

  function void fail(string what, logic [DriveW-1:0] want, logic [DriveW-1:0] got);
    n_failed++;
    if (n_failed <= 10) begin
      $display("mismatch: %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  function void check_drive(logic [DriveW-1:0] got);
    logic [DriveW-1:0] want;
    n_checked++;
    if (pending_drive.size() == 0) begin
      fail("drive with nothing pending", 'x, got);
    end else begin
      want = pending_drive.pop_front();
      if (got !== want) fail("drive", want, got);
    end
  endfunction

  function void close();
    if (pending_drive.size() != 0) begin
      n_failed += pending_drive.size();
      $display("%0d drive results never arrived", pending_drive.size());
    end
  endfunction
endclass

module tb;

  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;
  localparam int unsigned        Limit         = 400000;
  localparam int unsigned        LongHold      = 300;
  localparam int unsigned        Rounds        = 6;
  localparam int unsigned        RoundItems    = 122;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pic_in_if  in_if ();
  pic_out_if out_if ();

  incremental_pi_clamped u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  drive_tracker sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned n_speed = 0;
  int unsigned n_settings = 0;
  int unsigned n_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= Limit) begin
      $display("timed out after %0d cycles", n_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // transfers on both channels, sampled before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.take_speed(in_if.setpoint, in_if.measured);
        n_speed++;
      end
      if (out_if.valid && out_if.ready) sb.check_drive(out_if.drive);
    end
  end

  // result side: random back-pressure plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_left  = LongHold;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid is left high after the transfer so back-to-back items need no re-raise
  task automatic offer_speed(input logic [SpeedW-1:0] sp, input logic [SpeedW-1:0] ms);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.setpoint <= sp;
    in_if.measured <= ms;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_gain();
    logic [CfgDataW-1:0] g;
    g = ($urandom_range(3) == 0) ? CfgDataW'($urandom_range(255)) : CfgDataW'($urandom_range(6));
    // junk in the upper byte must be dropped by the 8-bit registers
    if ($urandom_range(3) == 0) g[CfgDataW-1:GainW] = 8'($urandom);
    return g;
  endfunction

  task automatic load_random_settings(input bit crossed);
    int unsigned lo;
    int unsigned hi;
    lo = $urandom_range(400);
    hi = ($urandom_range(3) == 0) ? $urandom_range(3000, 300) : $urandom_range(65535, lo + 100);
    if (crossed) begin
      lo = $urandom_range(65535);
      hi = $urandom_range(65535);
    end
    write_reg(CFG_PROP_GAIN, pick_gain());
    write_reg(CFG_INTEG_GAIN, pick_gain());
    write_reg(CFG_UPPER_THRESHOLD, CfgDataW'(hi));
    write_reg(CFG_LOWER_THRESHOLD, CfgDataW'(lo));
    write_reg(CFG_UPPER_VALUE, CfgDataW'($urandom));
    write_reg(CFG_LOWER_VALUE, CfgDataW'($urandom));
    if ($urandom_range(1)) write_reg(CfgIdxSpareHi, CfgDataW'($urandom));
    n_settings++;
  endtask

  initial begin
    logic [SpeedW-1:0] sp;
    logic [SpeedW-1:0] ms;
    int                near;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_PROP_GAIN;
    cfg_data_i     <= '0;
    in_if.valid    <= 1'b0;
    in_if.setpoint <= '0;
    in_if.measured <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 30;
    sink_idle_pct = 64;

    // full gains: huge positive error overflows past 16 bits, huge negative goes below zero
    write_reg(CFG_PROP_GAIN, 16'd255);
    write_reg(CFG_INTEG_GAIN, 16'd255);
    write_reg(CFG_UPPER_THRESHOLD, 16'hFFFF);
    write_reg(CFG_LOWER_THRESHOLD, 16'd0);
    write_reg(CFG_UPPER_VALUE, 16'd255);
    write_reg(CFG_LOWER_VALUE, 16'd0);
    n_settings++;
    offer_speed(8'd255, 8'd0);
    offer_speed(8'd0, 8'd255);
    offer_speed(8'd0, 8'd0);
    offer_speed(8'd255, 8'd255);
    settle();

    // small gains with a window wide enough for unclamped drive values
    write_reg(CFG_PROP_GAIN, 16'd3);
    write_reg(CFG_INTEG_GAIN, 16'd2);
    write_reg(CFG_UPPER_THRESHOLD, 16'd2000);
    write_reg(CFG_LOWER_THRESHOLD, 16'd50);
    write_reg(CFG_UPPER_VALUE, 16'd7);
    write_reg(CFG_LOWER_VALUE, 16'd200);
    n_settings++;
    offer_speed(8'd100, 8'd90);
    offer_speed(8'd120, 8'd100);
    offer_speed(8'd140, 8'd100);
    offer_speed(8'd100, 8'd100);
    offer_speed(8'd90, 8'd100);
    offer_speed(8'd60, 8'd100);
    settle();

    // overlapping window: both clamps hold and the low one must win
    write_reg(CFG_UPPER_THRESHOLD, 16'd100);
    write_reg(CFG_LOWER_THRESHOLD, 16'd60000);
    n_settings++;
    offer_speed(8'd200, 8'd100);
    offer_speed(8'd150, 8'd140);
    settle();

    // thresholds at opposite extremes
    write_reg(CFG_PROP_GAIN, 16'd255);
    write_reg(CFG_INTEG_GAIN, 16'd255);
    write_reg(CFG_UPPER_THRESHOLD, 16'd0);
    write_reg(CFG_LOWER_THRESHOLD, 16'hFFFF);
    n_settings++;
    offer_speed(8'd255, 8'd0);
    offer_speed(8'd0, 8'd255);
    offer_speed(8'd128, 8'd128);
    settle();

    // oversized data keeps its low bits; spare indexes change nothing
    write_reg(CFG_PROP_GAIN, 16'hAB05);
    write_reg(CFG_INTEG_GAIN, 16'h7F01);
    write_reg(CFG_UPPER_THRESHOLD, 16'd40000);
    write_reg(CFG_LOWER_THRESHOLD, 16'd20);
    write_reg(CFG_UPPER_VALUE, 16'hFF80);
    write_reg(CFG_LOWER_VALUE, 16'h1234);
    write_reg(CfgIdxSpareLo, 16'hFFFF);
    write_reg(CfgIdxSpareHi, 16'h0000);
    n_settings++;
    offer_speed(8'd10, 8'd10);
    offer_speed(8'd200, 8'd30);
    offer_speed(8'd30, 8'd200);
    settle();

    // zero gains hold the previous drive
    write_reg(CFG_PROP_GAIN, 16'd0);
    write_reg(CFG_INTEG_GAIN, 16'd0);
    n_settings++;
    offer_speed(8'd255, 8'd0);
    offer_speed(8'd1, 8'd254);
    settle();

    for (int r = 0; r < Rounds; r++) begin
      if (r < 2) begin
        src_idle_pct  = 30;
        sink_idle_pct = 64;
      end else if (r < 4) begin
        src_idle_pct  = 64;
        sink_idle_pct = 30;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      load_random_settings(r == 3);
      // receiver stalls for a long stretch while items keep coming
      if (r == 4) hold_req = 1'b1;
      for (int i = 0; i < RoundItems; i++) begin
        sp = SpeedW'($urandom_range(255));
        if ($urandom_range(3) != 0) begin
          near = int'(sp) + int'($urandom_range(24)) - 12;
          if (near < 0) near = 0;
          if (near > 255) near = 255;
          ms = near[SpeedW-1:0];
        end else begin
          ms = SpeedW'($urandom_range(255));
        end
        offer_speed(sp, ms);
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    sb.close();
    $display("run covered %0d speed samples and %0d drive checks over %0d register settings",
             n_speed, sb.n_checked, n_settings);
    $display("including clamp overlap, overflow past 16 bits, negative drive and a long stall");
    if (sb.n_failed == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", sb.n_failed);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
